### hw/rtl/wphs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the waypoint half-plane switcher.
package wphs_pkg;

  localparam int FIELD_W            = 24;    // coordinate field width on the channels
  localparam int SLOT_FIELD_W       = 4;     // wp_index / target_slot width
  localparam int THR_W              = 23;    // distance_threshold width
  localparam int COUNT_W            = 5;     // waypoint_count width
  localparam int CFG_DATA_W         = 23;    // widest register
  localparam int DEF_MAX_WAYPOINTS  = 16;
  localparam int DEF_COORD_BITS     = 24;

  localparam logic [THR_W-1:0]   THR_RESET   = 23'd2560;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

  // action codes
  localparam logic ACT_WRITE    = 1'b0;
  localparam logic ACT_POSITION = 1'b1;

  // register indexes
  typedef enum logic {
    REG_DIST_THRESHOLD = 1'b0,
    REG_WAYPOINT_COUNT = 1'b1
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_LAST,
    S_LOAD_CUR,
    S_LOAD_WAIT,
    S_PREP,
    S_MUL_A,
    S_DRAIN_A,
    S_DECIDE,
    S_MUL_B,
    S_DRAIN_B,
    S_CMP,
    S_MOD,
    S_FETCH,
    S_FETCH_WAIT,
    S_DONE
  } state_t;

  // multiplier schedule, in issue order
  typedef enum logic [4:0] {
    MS_EE0, MS_DD0, MS_ED0,
    MS_EE1, MS_DD1, MS_ED1,
    MS_EE2, MS_DD2, MS_ED2,
    MS_TT,
    MS_SS00, MS_SS01, MS_SS10, MS_SS11,
    MS_TL00, MS_TL01, MS_TL10, MS_TL11
  } mul_step_t;

endpackage

### hw/rtl/wphs_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces: input items, result items and register writes.

interface wphs_item_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   action;
  logic [wphs_pkg::SLOT_FIELD_W-1:0]      wp_index;
  logic signed [wphs_pkg::FIELD_W-1:0]    wp_north;
  logic signed [wphs_pkg::FIELD_W-1:0]    wp_east;
  logic signed [wphs_pkg::FIELD_W-1:0]    wp_down;
  logic signed [wphs_pkg::FIELD_W-1:0]    pos_north;
  logic signed [wphs_pkg::FIELD_W-1:0]    pos_east;
  logic signed [wphs_pkg::FIELD_W-1:0]    pos_down;

  modport source (output valid, action, wp_index, wp_north, wp_east, wp_down,
                  pos_north, pos_east, pos_down, input ready);
  modport sink   (input valid, action, wp_index, wp_north, wp_east, wp_down,
                  pos_north, pos_east, pos_down, output ready);
endinterface

interface wphs_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [wphs_pkg::FIELD_W-1:0]    target_n;
  logic signed [wphs_pkg::FIELD_W-1:0]    target_e;
  logic signed [wphs_pkg::FIELD_W-1:0]    target_d;
  logic signed [wphs_pkg::FIELD_W-1:0]    prev_n;
  logic signed [wphs_pkg::FIELD_W-1:0]    prev_e;
  logic signed [wphs_pkg::FIELD_W-1:0]    prev_d;
  logic [wphs_pkg::SLOT_FIELD_W-1:0]      target_slot;
  logic                                   advanced;

  modport source (output valid, target_n, target_e, target_d, prev_n, prev_e, prev_d,
                  target_slot, advanced, input ready);
  modport sink   (input valid, target_n, target_e, target_d, prev_n, prev_e, prev_d,
                  target_slot, advanced, output ready);
endinterface

interface wphs_cfg_if;
  logic                                   valid;
  logic                                   ready;
  wphs_pkg::reg_idx_t                     index;
  logic [wphs_pkg::CFG_DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/waypoint_half_plane_switcher.sv
`timescale 1ns / 1ps
// Waypoint half-plane switcher: waypoint table, leg tracking and switching test.
//
// Usage:
//  - item (sink): action 0 stores one waypoint at wp_index (slots at or beyond
//    MAX_WAYPOINTS are dropped); action 1 presents a vehicle position.
//  - result (source): one transaction per item: target, previous waypoint, target
//    slot and the advanced flag (always 0 for a write).
//  - cfg (sink, always ready): index 0 distance_threshold, 1 waypoint_count.
//    Write only while no item is in flight.
//  - Sequencing: a write goes straight to the result register. A position
//    item is decided by the radius or sign test, or else by the plane test,
//    which must form s^2 and thr^2*|d|^2; an advance adds the slot wrap and a
//    table read. The first position item after reset first loads the leg from
//    the table. The single shared multiplier gives one product per cycle; one
//    item at a time, the next accepted the cycle after the result register loads.
//  - The result sits in an output register: a stalled receiver does not keep a
//    new item from being accepted and worked on; only its hand-off waits.
//  - Reset: threshold to 2560 and count 1, leg and slot cleared, not started.
//    Table contents are undefined until written.
module waypoint_half_plane_switcher #(
  parameter int MAX_WAYPOINTS = wphs_pkg::DEF_MAX_WAYPOINTS,
  parameter int COORD_BITS    = wphs_pkg::DEF_COORD_BITS
) (
  input  logic                clk,
  input  logic                rst,
  wphs_item_if.sink           item,
  wphs_result_if.source       result,
  wphs_cfg_if.sink            cfg
);

  localparam int SLOT_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_WAYPOINTS + 1);
  localparam int MCNT_W = (CNT_W > 1) ? $clog2(CNT_W) : 1;
  localparam int WIDX_W = (SLOT_W > wphs_pkg::SLOT_FIELD_W) ? SLOT_W : wphs_pkg::SLOT_FIELD_W;
  localparam int E_W    = COORD_BITS + 1;               // signed difference
  localparam int MW     = COORD_BITS;                   // difference magnitude
  // limb width: magnitudes, thr, and two limbs hold every sum of squares
  localparam int LW     = (COORD_BITS + 1 > wphs_pkg::THR_W) ? COORD_BITS + 1 : wphs_pkg::THR_W;
  localparam int PW     = 2 * LW;
  localparam int AW     = 4 * LW;
  localparam int ROW_W  = 3 * COORD_BITS;

  // ---------------------------------------------------------------------------
  // coordinate conversion between the 24-bit fields and the internal width
  function automatic logic signed [COORD_BITS-1:0] coord_in(
      input logic signed [wphs_pkg::FIELD_W-1:0] v);
    logic signed [31:0] x;
    x = 32'(v);
    return x[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [wphs_pkg::FIELD_W-1:0] coord_out(
      input logic signed [COORD_BITS-1:0] v);
    logic signed [31:0] x;
    x = 32'(v);
    return x[wphs_pkg::FIELD_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // registers
  wphs_pkg::state_t    state, state_next;
  wphs_pkg::mul_step_t step, prod_step;

  logic [wphs_pkg::THR_W-1:0]   thr;
  logic [wphs_pkg::COUNT_W-1:0] wcount;
  logic                         started;
  logic [SLOT_W-1:0]            cur_slot;
  logic signed [COORD_BITS-1:0] cur_c  [3];   // target: north, east, down
  logic signed [COORD_BITS-1:0] last_c [3];   // start of leg
  logic signed [COORD_BITS-1:0] pos_c  [3];
  logic [MW-1:0]                me [3];
  logic [MW-1:0]                md [3];
  logic [2:0]                   neg;
  logic                         adv;

  logic [PW-1:0] dist2, len2, spos, sneg, thr2, s_val, prod;
  logic [AW-1:0] sq, rhs;
  logic          prod_vld;

  logic [CNT_W-1:0]  rem, num;
  logic [MCNT_W-1:0] mod_cnt;

  logic out_valid;

  // table memory, one row per waypoint
  logic [ROW_W-1:0]  mem [MAX_WAYPOINTS];
  logic [ROW_W-1:0]  rd_data;
  logic [SLOT_W-1:0] rd_addr;

  // ---------------------------------------------------------------------------
  // combinational helpers
  logic                 item_acc;
  logic [WIDX_W-1:0]    widx;
  logic                 wr_ok, wr_en;
  logic [SLOT_W-1:0]    wr_addr;
  logic [ROW_W-1:0]     wr_row;
  logic [CNT_W-1:0]     cnt_eff, cnt_m1;
  logic [WIDX_W-1:0]    slot_ext;
  logic                 early_adv, plane_adv;
  logic                 issue, out_load;
  logic [LW-1:0]        mul_a, mul_b;
  logic [CNT_W:0]       trial, trial_sub;
  logic signed [E_W-1:0] e_v [3];
  logic signed [E_W-1:0] d_v [3];

  assign item_acc = item.valid && item.ready;
  assign widx     = WIDX_W'(item.wp_index);
  assign wr_ok    = 32'(widx) < MAX_WAYPOINTS;
  assign wr_addr  = widx[SLOT_W-1:0];
  assign wr_row   = {coord_in(item.wp_down), coord_in(item.wp_east), coord_in(item.wp_north)};
  assign slot_ext = WIDX_W'(cur_slot);

  // count in use: zero means one, anything above the table saturates
  always_comb begin
    if (wcount == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (32'(wcount) > MAX_WAYPOINTS) begin
      cnt_eff = CNT_W'(MAX_WAYPOINTS);
    end else begin
      cnt_eff = CNT_W'(wcount);
    end
  end
  assign cnt_m1 = cnt_eff - CNT_W'(1);

  // leg vectors: e = p - target, d = target - previous
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e_v[k] = E_W'(pos_c[k]) - E_W'(cur_c[k]);
      d_v[k] = E_W'(cur_c[k]) - E_W'(last_c[k]);
    end
  end

  // inside the radius, or on/past the target along the leg
  assign early_adv = (dist2 < thr2) || (spos >= sneg);
  // before the target: past the offset plane when s^2 <= thr^2 * |d|^2
  assign plane_adv = (sq <= rhs);

  // one remainder bit per cycle for (slot + 1) mod count
  assign trial     = {rem, num[CNT_W-1]};
  assign trial_sub = trial - {1'b0, cnt_eff};

  // ---------------------------------------------------------------------------
  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wphs_pkg::S_IDLE: begin
        if (item.valid) begin
          if (item.action == wphs_pkg::ACT_POSITION) begin
            state_next = started ? wphs_pkg::S_PREP : wphs_pkg::S_LOAD_LAST;
          end else begin
            state_next = wphs_pkg::S_DONE;
          end
        end
      end
      wphs_pkg::S_LOAD_LAST:  state_next = wphs_pkg::S_LOAD_CUR;
      wphs_pkg::S_LOAD_CUR:   state_next = wphs_pkg::S_LOAD_WAIT;
      wphs_pkg::S_LOAD_WAIT:  state_next = wphs_pkg::S_PREP;
      wphs_pkg::S_PREP:       state_next = wphs_pkg::S_MUL_A;
      wphs_pkg::S_MUL_A: begin
        if (step == wphs_pkg::MS_TT) state_next = wphs_pkg::S_DRAIN_A;
      end
      wphs_pkg::S_DRAIN_A:    state_next = wphs_pkg::S_DECIDE;
      wphs_pkg::S_DECIDE:     state_next = early_adv ? wphs_pkg::S_MOD : wphs_pkg::S_MUL_B;
      wphs_pkg::S_MUL_B: begin
        if (step == wphs_pkg::MS_TL11) state_next = wphs_pkg::S_DRAIN_B;
      end
      wphs_pkg::S_DRAIN_B:    state_next = wphs_pkg::S_CMP;
      wphs_pkg::S_CMP:        state_next = plane_adv ? wphs_pkg::S_MOD : wphs_pkg::S_DONE;
      wphs_pkg::S_MOD: begin
        if (mod_cnt == MCNT_W'(CNT_W - 1)) state_next = wphs_pkg::S_FETCH;
      end
      wphs_pkg::S_FETCH:      state_next = wphs_pkg::S_FETCH_WAIT;
      wphs_pkg::S_FETCH_WAIT: state_next = wphs_pkg::S_DONE;
      wphs_pkg::S_DONE: begin
        if (!out_valid || result.ready) state_next = wphs_pkg::S_IDLE;
      end
      default:                state_next = wphs_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs
  always_comb begin
    item.ready = 1'b0;
    rd_addr    = '0;
    issue      = 1'b0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      wphs_pkg::S_IDLE: begin
        item.ready = 1'b1;
        wr_en      = item.valid && (item.action == wphs_pkg::ACT_WRITE) && wr_ok;
      end
      wphs_pkg::S_LOAD_LAST: rd_addr = cnt_m1[SLOT_W-1:0];
      wphs_pkg::S_LOAD_CUR:  rd_addr = '0;
      wphs_pkg::S_MUL_A,
      wphs_pkg::S_MUL_B:     issue = 1'b1;
      wphs_pkg::S_FETCH:     rd_addr = rem[SLOT_W-1:0];
      wphs_pkg::S_DONE:      out_load = !out_valid || result.ready;
      default: ;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      wphs_pkg::MS_EE0:  begin mul_a = LW'(me[0]); mul_b = LW'(me[0]); end
      wphs_pkg::MS_DD0:  begin mul_a = LW'(md[0]); mul_b = LW'(md[0]); end
      wphs_pkg::MS_ED0:  begin mul_a = LW'(me[0]); mul_b = LW'(md[0]); end
      wphs_pkg::MS_EE1:  begin mul_a = LW'(me[1]); mul_b = LW'(me[1]); end
      wphs_pkg::MS_DD1:  begin mul_a = LW'(md[1]); mul_b = LW'(md[1]); end
      wphs_pkg::MS_ED1:  begin mul_a = LW'(me[1]); mul_b = LW'(md[1]); end
      wphs_pkg::MS_EE2:  begin mul_a = LW'(me[2]); mul_b = LW'(me[2]); end
      wphs_pkg::MS_DD2:  begin mul_a = LW'(md[2]); mul_b = LW'(md[2]); end
      wphs_pkg::MS_ED2:  begin mul_a = LW'(me[2]); mul_b = LW'(md[2]); end
      wphs_pkg::MS_TT:   begin mul_a = LW'(thr);   mul_b = LW'(thr);   end
      wphs_pkg::MS_SS00: begin mul_a = s_val[LW-1:0];  mul_b = s_val[LW-1:0];  end
      wphs_pkg::MS_SS01: begin mul_a = s_val[LW-1:0];  mul_b = s_val[PW-1:LW]; end
      wphs_pkg::MS_SS10: begin mul_a = s_val[PW-1:LW]; mul_b = s_val[LW-1:0];  end
      wphs_pkg::MS_SS11: begin mul_a = s_val[PW-1:LW]; mul_b = s_val[PW-1:LW]; end
      wphs_pkg::MS_TL00: begin mul_a = thr2[LW-1:0];   mul_b = len2[LW-1:0];   end
      wphs_pkg::MS_TL01: begin mul_a = thr2[LW-1:0];   mul_b = len2[PW-1:LW];  end
      wphs_pkg::MS_TL10: begin mul_a = thr2[PW-1:LW];  mul_b = len2[LW-1:0];   end
      wphs_pkg::MS_TL11: begin mul_a = thr2[PW-1:LW];  mul_b = len2[PW-1:LW];  end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // table memory: write on accepted write items, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_data <= mem[rd_addr];
  end

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= wphs_pkg::THR_RESET;
      wcount <= wphs_pkg::COUNT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        wphs_pkg::REG_DIST_THRESHOLD: thr    <= cfg.data[wphs_pkg::THR_W-1:0];
        wphs_pkg::REG_WAYPOINT_COUNT: wcount <= cfg.data[wphs_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // state, leg and slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= wphs_pkg::S_IDLE;
      started  <= 1'b0;
      cur_slot <= '0;
      for (int k = 0; k < 3; k++) begin
        cur_c[k]  <= '0;
        last_c[k] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        wphs_pkg::S_LOAD_CUR: begin
          // read data holds slot count-1
          for (int k = 0; k < 3; k++) last_c[k] <= rd_data[k*COORD_BITS +: COORD_BITS];
        end
        wphs_pkg::S_LOAD_WAIT: begin
          for (int k = 0; k < 3; k++) cur_c[k] <= rd_data[k*COORD_BITS +: COORD_BITS];
          cur_slot <= '0;
          started  <= 1'b1;
        end
        wphs_pkg::S_FETCH: begin
          // remainder is cleared once the wrap is done, take it now
          cur_slot <= rem[SLOT_W-1:0];
        end
        wphs_pkg::S_FETCH_WAIT: begin
          for (int k = 0; k < 3; k++) begin
            last_c[k] <= cur_c[k];
            cur_c[k]  <= rd_data[k*COORD_BITS +: COORD_BITS];
          end
        end
        default: ;
      endcase
    end
  end

  // datapath: position capture, magnitudes, decision flag
  always_ff @(posedge clk) begin
    if (item_acc) begin
      pos_c[0] <= coord_in(item.pos_north);
      pos_c[1] <= coord_in(item.pos_east);
      pos_c[2] <= coord_in(item.pos_down);
      adv      <= 1'b0;
    end
    if (state == wphs_pkg::S_PREP) begin
      for (int k = 0; k < 3; k++) begin
        me[k]  <= e_v[k][E_W-1] ? MW'(-e_v[k]) : MW'(e_v[k]);
        md[k]  <= d_v[k][E_W-1] ? MW'(-d_v[k]) : MW'(d_v[k]);
        neg[k] <= e_v[k][E_W-1] ^ d_v[k][E_W-1];
      end
    end
    if (state == wphs_pkg::S_DECIDE) begin
      s_val <= sneg - spos;
      if (early_adv) adv <= 1'b1;
    end
    if (state == wphs_pkg::S_CMP && plane_adv) begin
      adv <= 1'b1;
    end
  end

  // shared multiplier, one product per cycle, accumulated the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    prod      <= mul_a * mul_b;
    prod_step <= step;
    if (state == wphs_pkg::S_PREP) begin
      step <= wphs_pkg::MS_EE0;
    end else if (issue && step != wphs_pkg::MS_TL11) begin
      step <= wphs_pkg::mul_step_t'(step + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == wphs_pkg::S_PREP) begin
      dist2 <= '0;
      len2  <= '0;
      spos  <= '0;
      sneg  <= '0;
      sq    <= '0;
      rhs   <= '0;
    end else if (prod_vld) begin
      case (prod_step)
        wphs_pkg::MS_EE0, wphs_pkg::MS_EE1, wphs_pkg::MS_EE2: dist2 <= dist2 + prod;
        wphs_pkg::MS_DD0, wphs_pkg::MS_DD1, wphs_pkg::MS_DD2: len2  <= len2 + prod;
        wphs_pkg::MS_ED0: if (neg[0]) sneg <= sneg + prod; else spos <= spos + prod;
        wphs_pkg::MS_ED1: if (neg[1]) sneg <= sneg + prod; else spos <= spos + prod;
        wphs_pkg::MS_ED2: if (neg[2]) sneg <= sneg + prod; else spos <= spos + prod;
        wphs_pkg::MS_TT:  thr2 <= prod;
        wphs_pkg::MS_SS00: sq <= sq + AW'(prod);
        wphs_pkg::MS_SS01,
        wphs_pkg::MS_SS10: sq <= sq + (AW'(prod) << LW);
        wphs_pkg::MS_SS11: sq <= sq + (AW'(prod) << (2 * LW));
        wphs_pkg::MS_TL00: rhs <= rhs + AW'(prod);
        wphs_pkg::MS_TL01,
        wphs_pkg::MS_TL10: rhs <= rhs + (AW'(prod) << LW);
        wphs_pkg::MS_TL11: rhs <= rhs + (AW'(prod) << (2 * LW));
        default: ;
      endcase
    end
  end

  // slot wrap: restoring remainder, MSB first
  always_ff @(posedge clk) begin
    if (state == wphs_pkg::S_MOD) begin
      rem     <= (trial >= {1'b0, cnt_eff}) ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      num     <= num << 1;
      mod_cnt <= mod_cnt + MCNT_W'(1);
    end else begin
      rem     <= '0;
      num     <= CNT_W'(cur_slot) + CNT_W'(1);
      mod_cnt <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.target_n    <= coord_out(cur_c[0]);
      result.target_e    <= coord_out(cur_c[1]);
      result.target_d    <= coord_out(cur_c[2]);
      result.prev_n      <= coord_out(last_c[0]);
      result.prev_e      <= coord_out(last_c[1]);
      result.prev_d      <= coord_out(last_c[2]);
      result.target_slot <= slot_ext[wphs_pkg::SLOT_FIELD_W-1:0];
      result.advanced    <= adv;
    end
  end

  assign result.valid = out_valid;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the waypoint half-plane switcher with a scoreboard class.
module tb;

  typedef logic signed [wphs_pkg::FIELD_W-1:0] coord_t;
  typedef logic [wphs_pkg::SLOT_FIELD_W-1:0]   slot_t;
  typedef logic [wphs_pkg::THR_W-1:0]          thr_t;
  typedef logic [wphs_pkg::COUNT_W-1:0]        cnt_t;
  typedef logic [wphs_pkg::CFG_DATA_W-1:0]     cfg_data_t;

  localparam coord_t C_MAX = 24'h7FFFFF;
  localparam coord_t C_MIN = 24'h800000;

  // One input transaction; index 0/1/2 of a coordinate array is north/east/down.
  typedef struct {
    logic                    action;
    slot_t                   wp_index;
    coord_t                  wp[3];
    coord_t                  pos[3];
  } item_t;

  // One result transaction: the leg after the item.
  typedef struct {
    coord_t                  tgt[3];
    coord_t                  prv[3];
    slot_t                   slot;
    logic                    adv;
  } leg_report_t;

  // Tracks the waypoint table and the leg being flown, and keeps the legs the
  // block must report, oldest first.
  class leg_scoreboard;
    coord_t                  wp_table[wphs_pkg::DEF_MAX_WAYPOINTS][3];
    coord_t                  tgt[3];
    coord_t                  prv[3];
    slot_t                   slot;
    bit                      started;
    thr_t                    thr;
    cnt_t                    count;
    leg_report_t             expected_legs[$];
    int                      mismatches;
    int                      n_writes;
    int                      n_positions;
    int                      n_switches;
    int                      n_settings;

    function new();
      foreach (wp_table[i, k]) wp_table[i][k] = '0;
      for (int k = 0; k < 3; k++) begin
        tgt[k] = '0;
        prv[k] = '0;
      end
      slot    = '0;
      started = 1'b0;
      thr     = wphs_pkg::THR_RESET;
      count   = wphs_pkg::COUNT_RESET;
    endfunction

    function void set_reg(wphs_pkg::reg_idx_t idx, cfg_data_t value);
      case (idx)
        wphs_pkg::REG_DIST_THRESHOLD: thr = value[wphs_pkg::THR_W-1:0];
        wphs_pkg::REG_WAYPOINT_COUNT: count = value[wphs_pkg::COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Count of 0 behaves as 1, anything above the table size is clipped.
    function int unsigned slots_in_use();
      if (count == 0) return 1;
      if (count > wphs_pkg::DEF_MAX_WAYPOINTS) return wphs_pkg::DEF_MAX_WAYPOINTS;
      return count;
    endfunction

    // Leg end point as the next position will see it (before the first
    // position the leg is still to be loaded from the table).
    function coord_t leg_point(bit of_target, int k);
      if (started) return of_target ? tgt[k] : prv[k];
      return of_target ? wp_table[0][k] : wp_table[slots_in_use() - 1][k];
    endfunction

    function void note_item(item_t it);
      leg_report_t         r;
      int unsigned         n;
      logic signed [127:0] pk, tk, lk, e, d, th, t2, dist2, len2, dot;
      logic                adv;
      adv = 1'b0;
      if (it.action == wphs_pkg::ACT_WRITE) begin
        for (int k = 0; k < 3; k++) wp_table[it.wp_index][k] = it.wp[k];
        n_writes++;
      end else begin
        n = slots_in_use();
        if (!started) begin
          started = 1'b1;
          for (int k = 0; k < 3; k++) begin
            prv[k] = wp_table[n - 1][k];
            tgt[k] = wp_table[0][k];
          end
          slot = '0;
        end
        dist2 = '0;
        len2  = '0;
        dot   = '0;
        for (int k = 0; k < 3; k++) begin
          pk = it.pos[k];
          tk = tgt[k];
          lk = prv[k];
          e = pk - tk;
          d = tk - lk;
          dist2 = dist2 + e * e;
          len2  = len2 + d * d;
          dot   = dot + e * d;
        end
        th = {105'b0, thr};
        t2 = th * th;
        // inside the radius, past the target, or past the plane thr short of it
        adv = (dist2 < t2) || (dot >= 0) || (dot * dot <= t2 * len2);
        if (adv) begin
          slot = slot_t'((32'(slot) + 1) % n);
          for (int k = 0; k < 3; k++) begin
            prv[k] = tgt[k];
            tgt[k] = wp_table[slot][k];
          end
          n_switches++;
        end
        n_positions++;
      end
      for (int k = 0; k < 3; k++) begin
        r.tgt[k] = tgt[k];
        r.prv[k] = prv[k];
      end
      r.slot = slot;
      r.adv  = adv;
      expected_legs.push_back(r);
    endfunction

    function void check_result(leg_report_t got);
      leg_report_t want;
      string       tgt_names[3];
      string       prv_names[3];
      tgt_names = '{"target_n", "target_e", "target_d"};
      prv_names = '{"prev_n", "prev_e", "prev_d"};
      if (expected_legs.size() == 0) begin
        $error("result transaction with no item outstanding");
        mismatches++;
        return;
      end
      want = expected_legs.pop_front();
      for (int k = 0; k < 3; k++) begin
        if (got.tgt[k] !== want.tgt[k]) begin
          $error("%s expected %0d got %0d", tgt_names[k], want.tgt[k], got.tgt[k]);
          mismatches++;
        end
        if (got.prv[k] !== want.prv[k]) begin
          $error("%s expected %0d got %0d", prv_names[k], want.prv[k], got.prv[k]);
          mismatches++;
        end
      end
      if (got.slot !== want.slot) begin
        $error("target_slot expected %0d got %0d", want.slot, got.slot);
        mismatches++;
      end
      if (got.adv !== want.adv) begin
        $error("advanced expected %0d got %0d", want.adv, got.adv);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  wphs_item_if   item_ch();
  wphs_result_if res_ch();
  wphs_cfg_if    cfg_ch();

  waypoint_half_plane_switcher DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #2 clk = ~clk;

  leg_scoreboard sb = new();
  // When set, neither side inserts idle cycles (back-to-back stretches).
  bit quiet;

  // Watchdog: the slowest legal run is well under a tenth of this.
  initial begin : watchdog
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stall before each transaction, then check it.
  initial begin : result_sink
    leg_report_t got;
    int unsigned stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid === 1'b1 && res_ch.ready === 1'b1));
      got.tgt[0] = res_ch.target_n;
      got.tgt[1] = res_ch.target_e;
      got.tgt[2] = res_ch.target_d;
      got.prv[0] = res_ch.prev_n;
      got.prv[1] = res_ch.prev_e;
      got.prv[2] = res_ch.prev_d;
      got.slot   = res_ch.target_slot;
      got.adv    = res_ch.advanced;
      sb.check_result(got);
    end
  end

  // Item side: random gap, then hold valid until the block takes the
  // transaction. Valid stays high on return so back-to-back items need no
  // extra edge; the next call with a gap, or a register write, lowers it.
  task automatic send_item(item_t it);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.action    <= it.action;
    item_ch.wp_index  <= it.wp_index;
    item_ch.wp_north  <= it.wp[0];
    item_ch.wp_east   <= it.wp[1];
    item_ch.wp_down   <= it.wp[2];
    item_ch.pos_north <= it.pos[0];
    item_ch.pos_east  <= it.pos[1];
    item_ch.pos_down  <= it.pos[2];
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    sb.note_item(it);
  endtask

  // Both registers, written only once every outstanding result is back.
  task automatic configure(thr_t thr_v, cnt_t cnt_v);
    item_ch.valid <= 1'b0;
    while (sb.expected_legs.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= wphs_pkg::REG_DIST_THRESHOLD;
    cfg_ch.data  <= cfg_data_t'(thr_v);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_reg(wphs_pkg::REG_DIST_THRESHOLD, cfg_data_t'(thr_v));
    cfg_ch.index <= wphs_pkg::REG_WAYPOINT_COUNT;
    cfg_ch.data  <= cfg_data_t'(cnt_v);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_reg(wphs_pkg::REG_WAYPOINT_COUNT, cfg_data_t'(cnt_v));
    cfg_ch.valid <= 1'b0;
    sb.n_settings++;
  endtask

  // Mostly small coordinates (within 64 metres) so legs and radii
  // interact; the rest anywhere in the signed Q16.8 range.
  function automatic coord_t rand_coord(bit wide);
    if (wide) return coord_t'($urandom);
    return coord_t'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic longint rand_off(int unsigned span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  // Ignored fields of every item are random so that they cannot matter.
  task automatic put_write(int unsigned idx, coord_t n, coord_t e, coord_t d);
    item_t it;
    it.action   = wphs_pkg::ACT_WRITE;
    it.wp_index = slot_t'(idx);
    it.wp       = '{n, e, d};
    it.pos      = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
    send_item(it);
  endtask

  task automatic put_position(coord_t n, coord_t e, coord_t d);
    item_t it;
    it.action   = wphs_pkg::ACT_POSITION;
    it.wp_index = slot_t'($urandom);
    it.wp       = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
    it.pos      = '{n, e, d};
    send_item(it);
  endtask

  // Random traffic: some waypoint rewrites, the rest positions placed
  // against the current leg so that both switching and holding occur.
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    int unsigned span;
    longint      t, p;
    it.action   = ($urandom_range(0, 99) < 12) ? wphs_pkg::ACT_WRITE : wphs_pkg::ACT_POSITION;
    it.wp_index = slot_t'($urandom);
    for (int k = 0; k < 3; k++) begin
      it.wp[k]  = rand_coord($urandom_range(0, 9) < 3);
      it.pos[k] = coord_t'($urandom);
    end
    if (it.action == wphs_pkg::ACT_POSITION) begin
      pick = $urandom_range(0, 9);
      span = sb.thr / 2 + 1;
      for (int k = 0; k < 3; k++) begin
        t = sb.leg_point(1'b1, k);
        p = sb.leg_point(1'b0, k);
        case (pick)
          0, 1, 2: it.pos[k] = coord_t'(t + rand_off(span));               // inside radius
          3, 4:    it.pos[k] = coord_t'(t + (t - p) / 4 + rand_off(span / 8 + 1)); // overshoot
          5, 6:    it.pos[k] = coord_t'(p + rand_off(span));               // near leg start
          7:       it.pos[k] = coord_t'(p + (t - p) / 2);                  // mid leg
          8:       it.pos[k] = coord_t'(t);                                // on the target
          default: ;                                                       // anywhere
        endcase
      end
    end
    return it;
  endfunction

  initial begin : stimulus
    thr_t thr_v;
    cnt_t cnt_v;
    rst               <= 1'b1;
    quiet              = 1'b0;
    item_ch.valid     <= 1'b0;
    item_ch.action    <= wphs_pkg::ACT_WRITE;
    item_ch.wp_index  <= '0;
    item_ch.wp_north  <= '0;
    item_ch.wp_east   <= '0;
    item_ch.wp_down   <= '0;
    item_ch.pos_north <= '0;
    item_ch.pos_east  <= '0;
    item_ch.pos_down  <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= wphs_pkg::REG_DIST_THRESHOLD;
    cfg_ch.data       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole table first so no unwritten slot is ever read.
    // Slots 0/1 hold the coordinate extremes, 2/3 coincide (zero-length leg).
    put_write(0, C_MAX, C_MIN, C_MAX);
    put_write(1, C_MIN, C_MAX, C_MIN);
    put_write(2, '0, '0, '0);
    put_write(3, '0, '0, '0);
    for (int s = 4; s < wphs_pkg::DEF_MAX_WAYPOINTS; s++)
      put_write(s, rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0));

    // Reset count of 1: leg from slot 0 to itself, so every position switches.
    put_position(C_MAX, C_MAX, C_MAX);
    put_position(C_MIN, C_MIN, C_MIN);

    // Zero radius, four slots: only the sign and plane tests can switch.
    configure('0, 5'd4);
    put_position(C_MIN, C_MAX, C_MIN);   // zero-length leg, moves on to slot 1
    put_position(C_MIN, C_MAX, C_MIN);   // exactly on slot 1: s = 0, switches
    put_position(C_MIN, C_MAX, C_MIN);   // back at leg start: holds
    put_position('0, '0, '0);            // on slot 2, switches onto the 2->3 zero leg
    put_position(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));

    // Full-scale radius.
    configure('1, 5'd16);
    put_position(C_MAX, C_MIN, C_MIN);

    // Random phases: thresholds from zero to full scale; counts of 0 and
    // above the table size exercise the clamp.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin thr_v = wphs_pkg::THR_RESET; cnt_v = 5'd16; end
        1: begin thr_v = '0;                cnt_v = 5'd5;  end
        2: begin thr_v = '1;                cnt_v = 5'd16; end
        3: begin thr_v = thr_t'(256);       cnt_v = 5'd2;  end
        4: begin thr_v = thr_t'($urandom);  cnt_v = 5'd0;  end
        5: begin thr_v = thr_t'($urandom_range(0, 4096)); cnt_v = 5'd20; end
        6: begin thr_v = thr_t'(1024);      cnt_v = 5'd1;  end
        7: begin thr_v = thr_t'($urandom_range(0, 65535)); cnt_v = 5'd31; end
        default: begin
          thr_v = thr_t'($urandom);
          cnt_v = cnt_t'($urandom_range(2, 16));
        end
      endcase
      quiet = (ph % 3 == 1);
      configure(thr_v, cnt_v);
      repeat (62) send_item(random_item());
    end

    // Drain, then allow for a stray extra result.
    item_ch.valid <= 1'b0;
    while (sb.expected_legs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Run covered %0d waypoint writes and %0d positions (%0d switches) under %0d settings.",
             sb.n_writes, sb.n_positions, sb.n_switches, sb.n_settings);
    $display("Radius from zero to full scale, slot counts 0 to 31, random stalls on both sides.");
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
